@@ rtl/wto_pkg.sv @@
// Shared constants, widths and codes of the wavetable oscillator bank.
package wto_pkg;

	localparam int TABLE_SIZE   = 4096;
	localparam int MAX_PARTIALS = 16;
	localparam int MAX_BEATS    = 4;
	localparam int FRAC_BITS    = 16;

	localparam int NUM_OSC = MAX_PARTIALS * MAX_BEATS;
	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int PHASE_W = IDX_W + FRAC_BITS;
	localparam int OSC_W   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
	localparam int PART_W  = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
	localparam int BEAT_W  = (MAX_BEATS > 1) ? $clog2(MAX_BEATS) : 1;
	localparam int PART_CNT_W = $clog2(MAX_PARTIALS + 1);
	localparam int BEAT_CNT_W = $clog2(MAX_BEATS + 1);

	// fixed field widths
	localparam int REQ_W      = 2;
	localparam int BIDX_W     = 2;
	localparam int PIDX_W     = 4;
	localparam int STEP_W     = 28;
	localparam int GAIN_W     = 16;
	localparam int ADDR_W     = 12;
	localparam int SAMP_W     = 16;
	localparam int SAMP_FRAC  = 15;
	localparam int SCALE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int APART_W    = 5;
	localparam int ABEAT_W    = 3;

	// shared multiplier and accumulator
	localparam int ACC_W     = 2 * SAMP_W + OSC_W;
	localparam int MUL_A_W   = ACC_W;
	localparam int MUL_B_W   = SCALE_W + 1;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int OUT_SHIFT = SAMP_FRAC + SCALE_W;
	localparam int Y_W       = PROD_W - OUT_SHIFT;

	localparam logic [CFG_IDX_W-1:0] CFG_PARTIALS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEATS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INC   = 2'd0,
		REQ_GAIN  = 2'd1,
		REQ_TABLE = 2'd2,
		REQ_TICK  = 2'd3
	} req_e_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDR,
		S_TBL0,
		S_TBL1,
		S_INTERP,
		S_GAIN,
		S_ACC,
		S_SCALE,
		S_ROUND
	} state_t;

endpackage

@@ rtl/wto_if.sv @@
// Request and result channel interfaces of the oscillator bank.
interface wto_req_if import wto_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic [BIDX_W-1:0]        beat_index;
	logic [PIDX_W-1:0]        partial_index;
	logic [STEP_W-1:0]        phase_step;
	logic [GAIN_W-1:0]        gain_value;
	logic [ADDR_W-1:0]        table_address;
	logic signed [SAMP_W-1:0] table_sample;

	modport source (
		output valid, req_type, beat_index, partial_index, phase_step,
		       gain_value, table_address, table_sample,
		input  ready
	);
	modport sink (
		input  valid, req_type, beat_index, partial_index, phase_step,
		       gain_value, table_address, table_sample,
		output ready
	);
endinterface

interface wto_res_if import wto_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SAMP_W-1:0] audio_sample;
	logic                     clipped;

	modport source (output valid, audio_sample, clipped, input ready);
	modport sink (input valid, audio_sample, clipped, output ready);
endinterface

@@ rtl/wavetable_oscillator_bank.sv @@
// Top level of the additive wavetable oscillator bank.
// Load requests (increment, gain, table) are stored when accepted. A tick walks
// the active oscillators one after another through a six-step sequence around
// one wave table read port and one shared multiplier (interpolate, weight, then
// accumulate); scale and round then bring its sample into the output register,
// and the final scale uses the same multiplier.
// Requests are held off while a tick runs; a waiting sample does not block loads.
module wavetable_oscillator_bank import wto_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wto_req_if.sink               requests,
	wto_res_if.source             samples
);

	state_t state_q, state_d;

	logic [APART_W-1:0] apart_q;
	logic [ABEAT_W-1:0] abeat_q;
	logic [SCALE_W-1:0] scale_q;

	logic [PART_CNT_W-1:0] np_q, np_d;
	logic [BEAT_CNT_W-1:0] nb_q, nb_d;
	logic [PART_W-1:0]     part_q;
	logic [BEAT_W-1:0]     beat_q;
	logic                  part_last, beat_last;
	logic [OSC_W-1:0]      osc_sel, osc_w;
	logic                  osc_w_ok;

	logic [NUM_OSC-1:0]   osc_vld_q;
	logic [GAIN_W-1:0]    gain_q [MAX_PARTIALS];
	logic [PHASE_W-1:0]   phase_q, phase_rd;
	logic [PHASE_W-1:0]   inc_q, inc_rd;
	logic signed [SAMP_W-1:0] s0_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic                 accept;
	logic                 res_valid_q, res_free;
	logic signed [SAMP_W-1:0] res_sample_q;
	logic                 res_clip_q;

	// RAM controls
	logic                 tbl_we;
	logic [IDX_W-1:0]     tbl_raddr;
	logic [SAMP_W-1:0]    tbl_rdata;
	logic                 inc_we;
	logic [PHASE_W-1:0]   inc_rdata;
	logic                 ph_we;
	logic [OSC_W-1:0]     ph_waddr;
	logic [PHASE_W-1:0]   ph_wdata;
	logic [PHASE_W-1:0]   ph_rdata;

	// shared multiplier
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [SAMP_W:0]   diff;
	logic signed [SAMP_W:0]   frac_term;
	logic signed [SAMP_W+1:0] v_sum;
	logic [PROD_W-1:0]        rnd;
	logic [Y_W-1:0]           y_full;
	logic                     y_fits;

	assign accept   = requests.valid && requests.ready;
	assign res_free = !res_valid_q || samples.ready;

	assign np_d = (32'(apart_q) > MAX_PARTIALS) ? PART_CNT_W'(MAX_PARTIALS)
	                                            : PART_CNT_W'(apart_q);
	assign nb_d = (32'(abeat_q) > MAX_BEATS) ? BEAT_CNT_W'(MAX_BEATS)
	                                         : BEAT_CNT_W'(abeat_q);

	assign part_last = (PART_CNT_W'(part_q) + PART_CNT_W'(1)) == np_q;
	assign beat_last = (BEAT_CNT_W'(beat_q) + BEAT_CNT_W'(1)) == nb_q;
	assign osc_sel   = OSC_W'(32'(beat_q) * MAX_PARTIALS + 32'(part_q));
	assign osc_w     = OSC_W'(32'(requests.beat_index) * MAX_PARTIALS
	                   + 32'(requests.partial_index));
	assign osc_w_ok  = (32'(requests.beat_index) < MAX_BEATS)
	                   && (32'(requests.partial_index) < MAX_PARTIALS);

	assign phase_rd = osc_vld_q[osc_sel] ? ph_rdata : '0;
	assign inc_rd   = osc_vld_q[osc_sel] ? inc_rdata : '0;

	assign diff      = $signed({tbl_rdata[SAMP_W-1], tbl_rdata}) - $signed({s0_q[SAMP_W-1], s0_q});
	assign frac_term = prod_q[FRAC_BITS +: SAMP_W+1];
	assign v_sum     = $signed({{2{s0_q[SAMP_W-1]}}, s0_q})
	                   + $signed({frac_term[SAMP_W], frac_term});

	assign rnd    = prod_q + (PROD_W'(1) << (OUT_SHIFT - 1));
	assign y_full = rnd[PROD_W-1:OUT_SHIFT];
	assign y_fits = (&y_full[Y_W-1:SAMP_FRAC]) || !(|y_full[Y_W-1:SAMP_FRAC]);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && requests.req_type == REQ_TICK) begin
					state_d = (np_d == '0 || nb_d == '0) ? S_SCALE : S_ADDR;
				end
			end
			S_ADDR:   state_d = S_TBL0;
			S_TBL0:   state_d = S_TBL1;
			S_TBL1:   state_d = S_INTERP;
			S_INTERP: state_d = S_GAIN;
			S_GAIN:   state_d = S_ACC;
			S_ACC:    state_d = (part_last && beat_last) ? S_SCALE : S_ADDR;
			S_SCALE:  state_d = S_ROUND;
			S_ROUND:  state_d = res_free ? S_IDLE : S_ROUND;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		requests.ready = 1'b0;
		tbl_we    = 1'b0;
		tbl_raddr = phase_rd[PHASE_W-1:FRAC_BITS];
		inc_we    = 1'b0;
		ph_we     = 1'b0;
		ph_waddr  = osc_w;
		ph_wdata  = '0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				requests.ready = 1'b1;
				if (accept && osc_w_ok && requests.req_type == REQ_INC) begin
					inc_we = 1'b1;
					ph_we  = 1'b1;
				end
				if (accept && requests.req_type == REQ_TABLE
				    && 32'(requests.table_address) < TABLE_SIZE) begin
					tbl_we = 1'b1;
				end
			end
			S_TBL1: begin
				tbl_raddr = IDX_W'(phase_q[PHASE_W-1:FRAC_BITS] + IDX_W'(1));
				ph_we     = 1'b1;
				ph_waddr  = osc_sel;
				ph_wdata  = phase_q + inc_q;
			end
			S_INTERP: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(diff);
				mul_b  = $signed(MUL_B_W'(phase_q[FRAC_BITS-1:0]));
			end
			S_GAIN: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'($signed(v_sum[SAMP_W-1:0]));
				mul_b  = $signed(MUL_B_W'(gain_q[part_q]));
			end
			S_SCALE: begin
				mul_en = 1'b1;
				mul_a  = acc_q;
				mul_b  = $signed(MUL_B_W'(scale_q));
			end
			S_ADDR, S_TBL0, S_ACC, S_ROUND: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			apart_q     <= APART_W'(1);
			abeat_q     <= ABEAT_W'(1);
			scale_q     <= '1;
			np_q        <= '0;
			nb_q        <= '0;
			part_q      <= '0;
			beat_q      <= '0;
			osc_vld_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (cfg_index == CFG_PARTIALS) apart_q <= cfg_data[APART_W-1:0];
				if (cfg_index == CFG_BEATS)    abeat_q <= cfg_data[ABEAT_W-1:0];
				if (cfg_index == CFG_SCALE)    scale_q <= cfg_data[SCALE_W-1:0];
			end
			if (inc_we) begin
				osc_vld_q[osc_w] <= 1'b1;
			end
			if (accept && requests.req_type == REQ_TICK) begin
				np_q   <= np_d;
				nb_q   <= nb_d;
				part_q <= '0;
				beat_q <= '0;
			end else if (state_q == S_ACC) begin
				if (part_last) begin
					part_q <= '0;
					beat_q <= BEAT_W'(beat_q + BEAT_W'(1));
				end else begin
					part_q <= PART_W'(part_q + PART_W'(1));
				end
			end
			if (state_q == S_ROUND && res_free) begin
				res_valid_q <= 1'b1;
			end else if (samples.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && requests.req_type == REQ_GAIN
		    && 32'(requests.partial_index) < MAX_PARTIALS) begin
			gain_q[PART_W'(requests.partial_index)] <= requests.gain_value;
		end
		if (accept && requests.req_type == REQ_TICK) begin
			acc_q <= '0;
		end else if (state_q == S_ACC) begin
			acc_q <= acc_q + prod_q[ACC_W-1:0];
		end
		if (state_q == S_TBL0) begin
			phase_q <= phase_rd;
			inc_q   <= inc_rd;
		end
		if (state_q == S_TBL1) begin
			s0_q <= tbl_rdata;
		end
		if (state_q == S_ROUND && res_free) begin
			res_clip_q   <= !y_fits;
			res_sample_q <= y_fits ? y_full[SAMP_W-1:0]
			                       : (y_full[Y_W-1] ? {1'b1, {(SAMP_W-1){1'b0}}}
			                                        : {1'b0, {(SAMP_W-1){1'b1}}});
		end
	end

	assign samples.valid        = res_valid_q;
	assign samples.audio_sample = res_sample_q;
	assign samples.clipped      = res_clip_q;

	wto_ram #(.WIDTH(SAMP_W), .DEPTH(TABLE_SIZE)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (IDX_W'(requests.table_address)),
		.wdata (requests.table_sample),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	wto_ram #(.WIDTH(PHASE_W), .DEPTH(NUM_OSC)) u_inc (
		.clk   (clk),
		.we    (inc_we),
		.waddr (osc_w),
		.wdata (PHASE_W'(requests.phase_step)),
		.raddr (osc_sel),
		.rdata (inc_rdata)
	);

	wto_ram #(.WIDTH(PHASE_W), .DEPTH(NUM_OSC)) u_phase (
		.clk   (clk),
		.we    (ph_we),
		.waddr (ph_waddr),
		.wdata (ph_wdata),
		.raddr (osc_sel),
		.rdata (ph_rdata)
	);

	wto_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	a_res_from_round: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_ROUND)
		else $error("sample presented without a finished tick");

	a_tick_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && requests.req_type == REQ_TICK |=> state_q != S_IDLE)
		else $error("tick transaction did not start the sequencer");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> (PART_CNT_W'(part_q) < np_q) && (BEAT_CNT_W'(beat_q) < nb_q))
		else $error("oscillator walk outside active range");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADDR |-> np_q != '0 && nb_q != '0)
		else $error("oscillator walk started with no active oscillators");

endmodule

@@ rtl/wto_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/wto_mul.sv @@
// Shared signed multiplier with registered product.
module wto_mul import wto_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule
